// ----- hdl/lccp_pkg.sv -----
package lccp_pkg;

   localparam int Q            = 3329;
   localparam int HALF_Q       = 1664;
   localparam int COEFF_COUNT  = 256;
   localparam int INDEX_W      = $clog2(COEFF_COUNT);

   // floor(t / q) == (t * RECIP) >> RECIP_SHIFT for every t below 2^22
   localparam int RECIP_SHIFT  = 34;
   localparam logic [22:0] RECIP = 23'd5160670;

   typedef logic [1:0] mode_type;
   typedef logic [3:0] width_type;

   localparam mode_type MODE_D1  = 2'd0;
   localparam mode_type MODE_D4  = 2'd1;
   localparam mode_type MODE_D10 = 2'd2;

   typedef struct packed {
      logic [9:0] code;
      width_type  width;
   } item_type;

   function automatic width_type code_width(input mode_type mode);
      width_type w;
      case (mode)
         MODE_D1: w = 4'd1;
         MODE_D4: w = 4'd4;
         default: w = 4'd10;
      endcase
      return w;
   endfunction

endpackage

// ----- hdl/lccp_compress.sv -----
module lccp_compress (
   input  logic signed [15:0] coefficient,
   input  lccp_pkg::mode_type mode,
   output lccp_pkg::item_type item
);
   import lccp_pkg::*;

   localparam logic signed [15:0] SAT_LOW  = 16'(-2 * Q);
   localparam logic signed [15:0] SAT_HIGH = 16'(3 * Q - 1);
   localparam logic signed [15:0] NEG_Q    = 16'(-Q);
   localparam logic signed [15:0] POS_Q    = 16'(Q);
   localparam logic signed [15:0] TWO_Q    = 16'(2 * Q);
   localparam logic signed [15:0] ZERO     = 16'sd0;

   logic signed [15:0] v_sat;
   logic signed [15:0] reduced;
   logic [11:0]        x;
   logic [21:0]        t;
   logic [44:0]        prod;
   logic [10:0]        quot;
   width_type          width;
   logic [10:0]        mask;

   always_comb begin
      if (coefficient < SAT_LOW) begin
         v_sat = SAT_LOW;
      end else if (coefficient > SAT_HIGH) begin
         v_sat = SAT_HIGH;
      end else begin
         v_sat = coefficient;
      end

      // pick the single multiple of q that lands in [0, q)
      if (v_sat < NEG_Q) begin
         reduced = v_sat + TWO_Q;
      end else if (v_sat < ZERO) begin
         reduced = v_sat + POS_Q;
      end else if (v_sat < POS_Q) begin
         reduced = v_sat;
      end else if (v_sat < TWO_Q) begin
         reduced = v_sat - POS_Q;
      end else begin
         reduced = v_sat - TWO_Q;
      end
      x = reduced[11:0];

      width = code_width(mode);
      t     = (22'(x) << width) + 22'(HALF_Q);
      prod  = 45'(t) * 45'(RECIP);
      quot  = prod[44:RECIP_SHIFT];
      mask  = (11'd1 << width) - 11'd1;

      item.code  = 10'(quot & mask);
      item.width = width;
   end

endmodule

// ----- hdl/lccp_packer.sv -----
module lccp_packer (
   input  logic               clock,
   input  logic               reset,
   input  logic               item_valid,
   input  lccp_pkg::item_type item,
   output logic               item_take,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [7:0]         rsp_packed_byte,
   output logic               rsp_run_last,
   output logic               rsp_poly_last
);
   import lccp_pkg::*;

   logic [6:0]         pending_bits_ff, pending_bits_in;
   logic [2:0]         pending_count_ff, pending_count_in;
   logic [INDEX_W-1:0] coeff_index_ff, coeff_index_in;
   logic [1:0]         out_count_ff, out_count_in;
   logic [7:0]         out_byte_ff [2];
   logic [7:0]         out_byte_in [2];
   logic [1:0]         out_run_last_ff, out_run_last_in;
   logic [1:0]         out_poly_last_ff, out_poly_last_in;

   logic [16:0] acc;
   logic [16:0] rest;
   logic [4:0]  total;
   logic [4:0]  remain;
   logic        two_bytes;
   logic        one_byte;
   logic        final_coeff;
   logic        pop;
   logic        load;

   assign rsp_valid       = (out_count_ff != 2'd0);
   assign rsp_packed_byte = out_byte_ff[0];
   assign rsp_run_last    = out_run_last_ff[0];
   assign rsp_poly_last   = out_poly_last_ff[0];

   assign pop       = rsp_valid && !rsp_stall;
   assign item_take = (out_count_ff == 2'd0) || ((out_count_ff == 2'd1) && pop);
   assign load      = item_valid && item_take;

   always_comb begin
      acc         = 17'(pending_bits_ff) | (17'(item.code) << pending_count_ff);
      total       = 5'(pending_count_ff) + 5'(item.width);
      two_bytes   = (total >= 5'd16);
      one_byte    = (total >= 5'd8) && !two_bytes;
      final_coeff = (coeff_index_ff >= INDEX_W'(COEFF_COUNT - 1));

      if (two_bytes) begin
         rest   = acc >> 16;
         remain = total - 5'd16;
      end else if (one_byte) begin
         rest   = acc >> 8;
         remain = total - 5'd8;
      end else begin
         rest   = acc;
         remain = total;
      end

      pending_bits_in  = pending_bits_ff;
      pending_count_in = pending_count_ff;
      coeff_index_in   = coeff_index_ff;
      out_count_in     = out_count_ff;
      out_byte_in      = out_byte_ff;
      out_run_last_in  = out_run_last_ff;
      out_poly_last_in = out_poly_last_ff;

      if (pop) begin
         out_count_in        = out_count_ff - 2'd1;
         out_byte_in[0]      = out_byte_ff[1];
         out_run_last_in[0]  = out_run_last_ff[1];
         out_poly_last_in[0] = out_poly_last_ff[1];
      end

      if (load) begin
         out_count_in        = {two_bytes, one_byte};
         out_byte_in[0]      = acc[7:0];
         out_byte_in[1]      = acc[15:8];
         out_run_last_in     = {1'b1, one_byte};
         out_poly_last_in    = {final_coeff, final_coeff && one_byte};
         if (final_coeff) begin
            // leftover bits are dropped so the next polynomial starts byte aligned
            pending_bits_in  = 7'd0;
            pending_count_in = 3'd0;
            coeff_index_in   = '0;
         end else begin
            pending_bits_in  = rest[6:0];
            pending_count_in = remain[2:0];
            coeff_index_in   = coeff_index_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_bits_ff  <= 7'd0;
         pending_count_ff <= 3'd0;
         coeff_index_ff   <= '0;
         out_count_ff     <= 2'd0;
      end else begin
         pending_bits_ff  <= pending_bits_in;
         pending_count_ff <= pending_count_in;
         coeff_index_ff   <= coeff_index_in;
         out_count_ff     <= out_count_in;
      end
   end

   always_ff @(posedge clock) begin
      out_byte_ff      <= out_byte_in;
      out_run_last_ff  <= out_run_last_in;
      out_poly_last_ff <= out_poly_last_in;
   end

   a_poly_implies_run: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_poly_last |-> rsp_run_last)
      else $error("poly_last without run_last");

   a_first_of_two: assert property (@(posedge clock) disable iff (reset)
      out_count_ff == 2'd2 |-> !out_run_last_ff[0])
      else $error("first of two bytes flagged as run end");

   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      out_count_ff != 2'd3)
      else $error("output queue overrun");

   a_poly_wrap: assert property (@(posedge clock) disable iff (reset)
      load && final_coeff |=> coeff_index_ff == '0 && pending_count_ff == 3'd0)
      else $error("polynomial end did not clear packing state");

endmodule

// ----- hdl/lattice_coeff_compress_pack_core.sv -----
// path: a req coefficient passes the input, compress and output registers to rsp
// throughput: one coefficient per cycle while each yields at most one byte and rsp
//   is not stalled; at 10-bit codes up to two bytes per coefficient leave the one-byte
//   rsp port, so the next coefficient is taken only as the last queued byte leaves
// reset: synchronous, clears mode (1-bit codes), packing bits, coefficient index, queue
module lattice_coeff_compress_pack_core (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic signed [15:0] req_coefficient,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [7:0]         rsp_packed_byte,
   output logic               rsp_run_last,
   output logic               rsp_poly_last,
   input  logic               csr_write_enable,
   input  logic [1:0]         csr_write_data
);
   import lccp_pkg::*;

   mode_type           mode_ff, mode_in;
   logic               s1_valid_ff, s1_valid_in;
   logic signed [15:0] coeff_ff, coeff_in;
   logic               s2_valid_ff, s2_valid_in;
   item_type           item_ff, item_in;
   item_type           comp_item;
   logic               item_take;
   logic               s2_free;
   logic               s1_move;
   logic               req_accept;

   assign s2_free    = !s2_valid_ff || item_take;
   assign s1_move    = s1_valid_ff && s2_free;
   assign req_stall  = s1_valid_ff && !s2_free;
   assign req_accept = req_valid && !req_stall;

   lccp_compress u_compress (
      .coefficient (coeff_ff),
      .mode        (mode_ff),
      .item        (comp_item)
   );

   always_comb begin
      mode_in     = csr_write_enable ? csr_write_data : mode_ff;
      s1_valid_in = req_accept || (s1_valid_ff && !s1_move);
      coeff_in    = req_accept ? req_coefficient : coeff_ff;
      s2_valid_in = s1_move || (s2_valid_ff && !item_take);
      item_in     = s1_move ? comp_item : item_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff     <= MODE_D1;
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         mode_ff     <= mode_in;
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      coeff_ff <= coeff_in;
      item_ff  <= item_in;
   end

   lccp_packer u_packer (
      .clock           (clock),
      .reset           (reset),
      .item_valid      (s2_valid_ff),
      .item            (item_ff),
      .item_take       (item_take),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_packed_byte (rsp_packed_byte),
      .rsp_run_last    (rsp_run_last),
      .rsp_poly_last   (rsp_poly_last)
   );

endmodule

// ----- verif/tb_lattice_coeff_compress_pack_core.sv -----
module tb_lattice_coeff_compress_pack_core;
   timeunit 1ns;
   timeprecision 1ps;

   import lccp_pkg::*;

   localparam mode_type MODE_UNUSED = 2'd3;
   localparam int SETTLE_CYCLES = 8;
   localparam int QUIET_LIMIT   = 2000;
   localparam int PRINT_CAP     = 40;

   typedef struct packed {
      logic [7:0] packed_byte;
      logic       run_last;
      logic       poly_last;
   } byte_expect_type;

   logic               clock = 1'b0;
   logic               reset;
   logic               req_valid;
   logic               req_stall;
   logic signed [15:0] req_coefficient;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic [7:0]         rsp_packed_byte;
   logic               rsp_run_last;
   logic               rsp_poly_last;
   logic               csr_write_enable;
   logic [1:0]         csr_write_data;

   // shadow of the block state
   mode_type    mode_shadow;
   logic [6:0]  held_bits;
   logic [2:0]  held_count;
   int unsigned poly_pos;

   byte_expect_type byte_queue[$];

   int send_idle_pct;
   int recv_stall_pct;
   int error_count;
   int coeff_sent;
   int bytes_checked;
   int poly_ends_seen;
   int quiet_cycles;
   logic [3:0] modes_used;

   lattice_coeff_compress_pack_core u_top (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_coefficient  (req_coefficient),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_packed_byte  (rsp_packed_byte),
      .rsp_run_last     (rsp_run_last),
      .rsp_poly_last    (rsp_poly_last),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   always #2 clock = ~clock;

   task automatic report_mismatch(input string what, input int want, input int got);
      if (error_count < PRINT_CAP)
         $display("%0t ERROR %s: expected %0d got %0d", $realtime, what, want, got);
      error_count++;
   endtask

   // saturate, reduce mod q, compress, then pack into bytes lsb first
   function automatic void predict_bytes(input logic signed [15:0] coeff);
      int              v;
      int unsigned     d;
      int unsigned     code;
      int unsigned     acc;
      int unsigned     total;
      bit              last_coeff;
      int              n;
      byte_expect_type made[2];
      v = coeff;
      if (v < -2 * Q) v = -2 * Q;
      if (v > 3 * Q - 1) v = 3 * Q - 1;
      if (v < 0) v += Q;
      if (v < 0) v += Q;
      if (v >= Q) v -= Q;
      if (v >= Q) v -= Q;
      case (mode_shadow)
         MODE_D1: d = 1;
         MODE_D4: d = 4;
         default: d = 10;
      endcase
      code = ((unsigned'(v) << d) + HALF_Q) / Q;
      code = code & ((1 << d) - 1);
      acc = held_bits | (code << held_count);
      total = held_count + d;
      last_coeff = (poly_pos >= COEFF_COUNT - 1);
      n = 0;
      while (total >= 8 && n < 2) begin
         made[n].packed_byte = acc[7:0];
         made[n].run_last = 1'b0;
         made[n].poly_last = 1'b0;
         acc = acc >> 8;
         total -= 8;
         n++;
      end
      if (n > 0) begin
         made[n - 1].run_last = 1'b1;
         made[n - 1].poly_last = last_coeff;
      end
      for (int i = 0; i < n; i++) byte_queue.push_back(made[i]);
      if (last_coeff) begin
         held_bits = '0;
         held_count = '0;
         poly_pos = 0;
      end else begin
         held_bits = 7'(acc & ((1 << total) - 1));
         held_count = total[2:0];
         poly_pos++;
      end
   endfunction

   task automatic send_coefficient(input logic signed [15:0] coeff);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_coefficient <= coeff;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predict_bytes(coeff);
      coeff_sent++;
   endtask

   // hold the sender until every expected byte has come, then let the pipe settle
   task automatic wait_drained();
      req_valid <= 1'b0;
      while (byte_queue.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_compress_mode(input mode_type m);
      wait_drained();
      csr_write_enable <= 1'b1;
      csr_write_data <= m;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      mode_shadow = m;
      modes_used[m] = 1'b1;
   endtask

   function automatic logic signed [15:0] pick_coefficient();
      int sel;
      int v;
      sel = $urandom_range(99);
      if (sel < 40)
         v = int'($urandom_range(65535)) - 32768;
      else if (sel < 80)
         v = int'($urandom_range(16644)) - 6658;
      else
         // near multiples of q, including the saturation edges
         v = (int'($urandom_range(5)) - 2) * Q + int'($urandom_range(4)) - 2;
      return v[15:0];
   endfunction

   task automatic test_directed_extremes();
      // reset mode is 1-bit codes; values around the rounding points
      send_coefficient(16'sd832);
      send_coefficient(16'sd833);
      send_coefficient(16'sd2496);
      send_coefficient(16'sd2497);
      set_compress_mode(MODE_D10);
      send_coefficient(-16'sd32768);
      send_coefficient(16'sd32767);
      send_coefficient(-16'sd6659);
      send_coefficient(-16'sd6658);
      send_coefficient(16'sd9986);
      send_coefficient(16'sd9987);
      send_coefficient(-16'sd1);
      send_coefficient(16'sd0);
      send_coefficient(16'sd3328);
      send_coefficient(16'sd3329);
   endtask

   task automatic test_unused_mode();
      // the spare encoding behaves as 10-bit codes
      set_compress_mode(MODE_UNUSED);
      send_coefficient(16'sd1664);
      send_coefficient(-16'sd3330);
      send_coefficient(16'sd6658);
   endtask

   task automatic test_mode_switch_midstream();
      // partial bits stay pending across each width change
      set_compress_mode(MODE_D4);
      send_coefficient(16'sd1000);
      set_compress_mode(MODE_D10);
      send_coefficient(16'sd2000);
      send_coefficient(-16'sd500);
      set_compress_mode(MODE_D1);
      send_coefficient(16'sd1700);
      send_coefficient(16'sd3000);
      set_compress_mode(MODE_D4);
      send_coefficient(16'sd4000);
      send_coefficient(-16'sd4000);
   endtask

   task automatic test_polynomial_tail();
      // last coefficient at 1-bit width: a partial byte is dropped, next polynomial aligned
      set_compress_mode(MODE_D10);
      send_coefficient(pick_coefficient());
      while (poly_pos != COEFF_COUNT - 1) send_coefficient(pick_coefficient());
      set_compress_mode(MODE_D1);
      send_coefficient(pick_coefficient());
      set_compress_mode(MODE_D4);
      for (int i = 0; i < 8; i++) send_coefficient(pick_coefficient());
   endtask

   task automatic test_random_stream(input int count);
      int left;
      int chunk;
      left = count;
      while (left > 0) begin
         set_compress_mode(mode_type'($urandom_range(3)));
         chunk = $urandom_range(60, 8);
         if (chunk > left) chunk = left;
         for (int i = 0; i < chunk; i++) send_coefficient(pick_coefficient());
         left -= chunk;
      end
   endtask

   task automatic finish_run();
      wait_drained();
      if (byte_queue.size() != 0)
         report_mismatch("bytes never delivered", byte_queue.size(), 0);
      $display("sent %0d coefficients, checked %0d packed bytes, %0d polynomial ends",
               coeff_sent, bytes_checked, poly_ends_seen);
      $display("code width settings used (mask) %b, under three sender/receiver idling mixes",
               modes_used);
      if (error_count == 0)
         $display("lattice_coeff_compress_pack_core: match");
      else
         $display("lattice_coeff_compress_pack_core: mismatch");
      $finish;
   endtask

   always @(posedge clock) begin
      if (reset)
         rsp_stall <= 1'b0;
      else
         rsp_stall <= ($urandom_range(99) < recv_stall_pct);
   end

   always @(posedge clock) begin
      byte_expect_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (byte_queue.size() == 0) begin
            report_mismatch("byte with nothing expected", -1, int'(rsp_packed_byte));
         end else begin
            want = byte_queue.pop_front();
            if (rsp_packed_byte !== want.packed_byte)
               report_mismatch("packed_byte", int'(want.packed_byte),
                               int'(rsp_packed_byte));
            if (rsp_run_last !== want.run_last)
               report_mismatch("run_last", int'(want.run_last), int'(rsp_run_last));
            if (rsp_poly_last !== want.poly_last)
               report_mismatch("poly_last", int'(want.poly_last), int'(rsp_poly_last));
         end
         bytes_checked++;
         if (rsp_poly_last === 1'b1) poly_ends_seen++;
      end
   end

   always @(posedge clock) begin
      if ((!reset && req_valid && !req_stall) || (!reset && rsp_valid && !rsp_stall))
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("timeout: no transaction for %0d cycles", QUIET_LIMIT);
         $display("lattice_coeff_compress_pack_core: mismatch");
         $finish;
      end
   end

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_coefficient = '0;
      csr_write_enable = 1'b0;
      csr_write_data = MODE_D1;
      mode_shadow = MODE_D1;
      held_bits = '0;
      held_count = '0;
      poly_pos = 0;
      error_count = 0;
      coeff_sent = 0;
      bytes_checked = 0;
      poly_ends_seen = 0;
      quiet_cycles = 0;
      modes_used = 4'b0001;
      send_idle_pct = 12;
      recv_stall_pct = 50;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      test_directed_extremes();
      test_unused_mode();
      test_mode_switch_midstream();
      test_random_stream(230);

      send_idle_pct = 50;
      recv_stall_pct = 12;
      test_polynomial_tail();
      test_random_stream(150);

      send_idle_pct = 0;
      recv_stall_pct = 0;
      test_random_stream(230);

      finish_run();
   end

endmodule
